### rtl/rud_pkg.sv
// Shared types for the restoring unsigned divider.
`timescale 1ns / 1ps

package rud_pkg;

  // Per-cell control that travels down the chain with each operand pair
  typedef struct packed {
    logic valid;
    logic dbz;
  } rud_ctl_t;

endpackage

### rtl/rud_if.sv
// Valid/ready channel interfaces for operands and results of the divider.
`timescale 1ns / 1ps

interface rud_operand_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] dividend;
  logic [DATA_WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface rud_result_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH-1:0] remainder;
  logic                  divide_by_zero;

  modport source (output valid, output quotient, output remainder,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input quotient, input remainder,
                  input divide_by_zero, output ready);
endinterface

### rtl/rud_cell.sv
// One restoring-division cell: a single shift, trial subtract and quotient bit.
`timescale 1ns / 1ps

module rud_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  rud_pkg::rud_ctl_t         ctl_in,
  input  logic [2*DATA_WIDTH-1:0]   acc_in,
  input  logic [DATA_WIDTH-1:0]     div_in,
  output rud_pkg::rud_ctl_t         ctl_out,
  output logic [2*DATA_WIDTH-1:0]   acc_out,
  output logic [DATA_WIDTH-1:0]     div_out
);
  import rud_pkg::*;

  // acc holds {partial remainder, unused dividend bits / quotient bits so far}
  logic [DATA_WIDTH:0]     trial;
  logic [DATA_WIDTH:0]     diff;
  logic                    fits;
  logic [2*DATA_WIDTH-1:0] acc_next;
  rud_ctl_t                ctl;
  logic [2*DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0]   div;

  // Shift the remainder left by one and try the divisor against it
  always_comb begin
    trial = acc_in[2*DATA_WIDTH-1:DATA_WIDTH-1];
    diff  = trial - {1'b0, div_in};
    fits  = (trial >= {1'b0, div_in});
    if (fits) begin
      acc_next = {diff[DATA_WIDTH-1:0], acc_in[DATA_WIDTH-2:0], 1'b1};
    end else begin
      acc_next = {trial[DATA_WIDTH-1:0], acc_in[DATA_WIDTH-2:0], 1'b0};
    end
  end

  // Advance control with reset; payload holds no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
      ctl.dbz   <= 1'b0;
    end else if (advance) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      acc <= acc_next;
      div <= div_in;
    end
  end

  assign ctl_out = ctl;
  assign acc_out = acc;
  assign div_out = div;

endmodule

### rtl/restoring_unsigned_divider_unit.sv
// Radix-2 restoring unsigned divider built as a chain of DATA_WIDTH step cells.
// Throughput: one item per cycle; each cell does one quotient bit. The transfer
// loads the first cell; the result then passes the other DATA_WIDTH-1 cells and
// the output register. The chain stalls only while a finished result waits on a full output.
// Reset (rst, synchronous): empties every cell and the output register.
`timescale 1ns / 1ps

module restoring_unsigned_divider_unit #(
  parameter int DATA_WIDTH = 32
) (
  input logic           clk,
  input logic           rst,
  rud_operand_if.sink   operands,
  rud_result_if.source  results
);
  import rud_pkg::*;

  rud_ctl_t                ctl_chain [DATA_WIDTH+1];
  logic [2*DATA_WIDTH-1:0] acc_chain [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]   div_chain [DATA_WIDTH+1];

  logic                    advance;
  rud_ctl_t                last;
  logic                    res_valid;
  logic [DATA_WIDTH-1:0]   res_quotient;
  logic [DATA_WIDTH-1:0]   res_remainder;
  logic                    res_dbz;

  assign last = ctl_chain[DATA_WIDTH];

  // Hold the chain only when the last cell has a result and the output is blocked
  assign advance = !(last.valid && res_valid && !results.ready);
  assign operands.ready = advance;

  // Feed the first cell: remainder starts at zero, dividend fills the low half
  assign ctl_chain[0].valid = operands.valid;
  assign ctl_chain[0].dbz   = (operands.divisor == '0);
  assign acc_chain[0]       = {{DATA_WIDTH{1'b0}}, operands.dividend};
  assign div_chain[0]       = operands.divisor;

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    rud_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .ctl_in  (ctl_chain[k]),
      .acc_in  (acc_chain[k]),
      .div_in  (div_chain[k]),
      .ctl_out (ctl_chain[k+1]),
      .acc_out (acc_chain[k+1]),
      .div_out (div_chain[k+1])
    );
  end

  // Output register: drop on transfer, load when the chain delivers
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && last.valid) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Divide by zero leaves all-ones in the quotient half; force it to zero
  always_ff @(posedge clk) begin
    if (advance && last.valid) begin
      res_quotient  <= last.dbz ? '0 : acc_chain[DATA_WIDTH][DATA_WIDTH-1:0];
      res_remainder <= acc_chain[DATA_WIDTH][2*DATA_WIDTH-1:DATA_WIDTH];
      res_dbz       <= last.dbz;
    end
  end

  assign results.valid          = res_valid;
  assign results.quotient       = res_quotient;
  assign results.remainder      = res_remainder;
  assign results.divide_by_zero = res_dbz;

endmodule

### rtl/rud_checker.sv
// Port-level checks for the restoring unsigned divider, bound to the top level.
`timescale 1ns / 1ps

module rud_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_quotient,
  input logic [DATA_WIDTH-1:0] out_remainder,
  input logic                  out_dbz
);

  // No result shows in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Operand side is held only by result backpressure
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("operand ready low without result backpressure");

  // Divide by zero always reports a zero quotient
  a_dbz_quot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_dbz) |-> (out_quotient == '0))
    else $error("nonzero quotient on divide by zero");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_quotient) && $stable(out_remainder) && $stable(out_dbz)))
    else $error("stalled result changed");

endmodule

bind restoring_unsigned_divider_unit rud_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_rud_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (operands.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_quotient  (results.quotient),
  .out_remainder (results.remainder),
  .out_dbz       (results.divide_by_zero)
);
